/* design/csd_pkg.sv */
package csd_pkg;

  // Decoder position within a block.
  typedef enum logic [1:0] {
    MODE_CODE  = 2'd0,  // next byte is a code byte
    MODE_DATA  = 2'd1,  // next byte is a data byte
    MODE_DELIM = 2'd2,  // implied delimiter due at next code byte
    MODE_RUN   = 2'd3   // implied run due at next code byte
  } csd_mode_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } csd_kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DELIM    = 2'd0,
    REG_DEPTH    = 2'd1,
    REG_RUN_LEN  = 2'd2,
    REG_RUN_BYTE = 2'd3
  } csd_reg_t;

  localparam logic [7:0] SWAP_LIMIT    = 8'd127;  // codes above this mark a run
  localparam logic [7:0] DELIM_RST     = 8'd0;
  localparam logic [7:0] DEPTH_RST     = 8'd255;
  localparam logic [3:0] RUN_LEN_RST   = 4'd0;
  localparam logic [7:0] RUN_BYTE_RST  = 8'd0;
  // Effective depth with the reset register values (extension off).
  localparam logic [7:0] BLK_CNT_RST   = 8'd255;

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] depth;
    logic [3:0] run_len;
    logic [7:0] run_byte;
  } csd_cfg_t;

  typedef struct packed {
    csd_mode_t  mode;
    logic [7:0] swap_cnt;
    logic [7:0] blk_cnt;
    logic       run_pend;
  } csd_state_t;

endpackage

/* design/csd_step.sv */
// Next-state and result burst for one received byte.
module csd_step #(
  parameter int MAX_RUN_LENGTH = 8,
  parameter int MIN_DEPTH      = 2,
  parameter int CNT_W          = $clog2(MAX_RUN_LENGTH + 1)
) (
  input  csd_pkg::csd_cfg_t   cfg,
  input  csd_pkg::csd_state_t st,
  input  logic [7:0]          in_byte,
  output csd_pkg::csd_state_t st_next,
  output logic                emit_vld,
  output csd_pkg::csd_kind_t  emit_kind,
  output logic [7:0]          emit_byte,
  output logic [CNT_W-1:0]    emit_cnt
);

  logic             run_on;
  logic             run_sat;
  logic [CNT_W-1:0] run_eff;
  logic [7:0]       depth_clamp;
  logic [7:0]       depth;
  logic [7:0]       code_raw;
  logic             run_code;
  logic [7:0]       code;
  logic             bad_code;
  logic             in_code;
  logic [7:0]       sc_dec;
  logic [7:0]       bc_dec;
  logic             rp;
  csd_pkg::csd_mode_t mode_adv;

  // Effective run length: below 2 is off, saturates at MAX_RUN_LENGTH.
  assign run_on  = (cfg.run_len >= 4'd2);
  assign run_sat = ({4'd0, cfg.run_len} > 8'(MAX_RUN_LENGTH));
  assign run_eff = !run_on ? '0 :
                   run_sat ? CNT_W'(MAX_RUN_LENGTH) : CNT_W'(cfg.run_len);

  assign depth_clamp = (run_on && cfg.depth > csd_pkg::SWAP_LIMIT) ?
                       csd_pkg::SWAP_LIMIT : cfg.depth;
  assign depth = (depth_clamp < 8'(MIN_DEPTH)) ? 8'(MIN_DEPTH) : depth_clamp;

  // Encoder swaps a nonzero delimiter with zero.
  assign code_raw = (cfg.delim != 8'd0 && in_byte == 8'd0) ? cfg.delim : in_byte;
  assign run_code = run_on && (code_raw > csd_pkg::SWAP_LIMIT);
  assign code     = run_code ? (code_raw - csd_pkg::SWAP_LIMIT) : code_raw;
  assign bad_code = (code == 8'd0) || (code > depth);

  assign in_code = (st.mode != csd_pkg::MODE_DATA);
  assign sc_dec  = (in_code ? code : st.swap_cnt) - 8'd1;
  assign bc_dec  = (in_code ? depth : st.blk_cnt) - 8'd1;
  assign rp      = in_code ? run_code : st.run_pend;

  always_comb begin
    if (bc_dec == 8'd0) begin
      mode_adv = csd_pkg::MODE_CODE;
    end else if (sc_dec == 8'd0) begin
      mode_adv = rp ? csd_pkg::MODE_RUN : csd_pkg::MODE_DELIM;
    end else begin
      mode_adv = csd_pkg::MODE_DATA;
    end
  end

  always_comb begin
    st_next   = st;
    emit_vld  = 1'b0;
    emit_kind = csd_pkg::KIND_DATA;
    emit_byte = 8'd0;
    emit_cnt  = CNT_W'(1);
    if (in_byte == cfg.delim) begin
      // Frame end, or error when it cuts a block short.
      st_next.mode    = csd_pkg::MODE_CODE;
      st_next.blk_cnt = depth;
      emit_vld        = 1'b1;
      emit_kind       = in_code ? csd_pkg::KIND_END : csd_pkg::KIND_ERR;
    end else if (in_code && bad_code) begin
      st_next.mode     = csd_pkg::MODE_CODE;
      st_next.swap_cnt = code;
      st_next.blk_cnt  = depth;
      st_next.run_pend = run_code;
      emit_vld         = 1'b1;
      emit_kind        = csd_pkg::KIND_ERR;
    end else begin
      st_next.mode     = mode_adv;
      st_next.swap_cnt = sc_dec;
      st_next.blk_cnt  = (bc_dec == 8'd0) ? depth : bc_dec;
      st_next.run_pend = rp;
      case (st.mode)
        csd_pkg::MODE_DATA: begin
          emit_vld  = 1'b1;
          emit_byte = in_byte;
        end
        csd_pkg::MODE_DELIM: begin
          emit_vld  = 1'b1;
          emit_byte = cfg.delim;
        end
        csd_pkg::MODE_RUN: begin
          emit_vld  = (run_eff != '0);
          emit_byte = cfg.run_byte;
          emit_cnt  = run_eff;
        end
        default: begin
          emit_vld = 1'b0;
        end
      endcase
    end
  end

endmodule

/* design/cobs_stream_decoder_unit.sv */
// Path: a byte accepted into the input register is decoded once the result
//   register is free, and its first result is then on the master side.
// Throughput: one byte per cycle unless the output stalls; a run of N copies
//   holds the output until all N leave; input stalls once its register fills.
// Reset (rst, synchronous, active high): registers return to their reset
//   values, decoder expects a code byte, both pipeline registers empty.
module cobs_stream_decoder_unit #(
  parameter int MAX_RUN_LENGTH = 8,   // 2..64, longest implied run
  parameter int MIN_DEPTH      = 2    // 1..127, floor on the block depth
) (
  input  logic       clk,
  input  logic       rst,
  // input byte stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  // decoded result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [1:0] kind
  output logic       m_tlast,   // final result caused by one input byte
  // configuration writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_RUN_LENGTH + 1);

  csd_pkg::csd_cfg_t   cfg;
  csd_pkg::csd_state_t st;
  csd_pkg::csd_state_t st_next;

  // Input register: holds one accepted request until the decode step runs.
  logic       in_vld;
  logic [7:0] in_byte;

  // Result register: one burst of identical results, counted down on output.
  logic               ob_vld;
  csd_pkg::csd_kind_t ob_kind;
  logic [7:0]         ob_byte;
  logic [CNT_W-1:0]   ob_cnt;

  logic               emit_vld;
  csd_pkg::csd_kind_t emit_kind;
  logic [7:0]         emit_byte;
  logic [CNT_W-1:0]   emit_cnt;

  logic ob_free;  // result register empty after this cycle
  logic fire;     // decode step runs this cycle

  assign ob_free  = !ob_vld || (m_tready && ob_cnt == CNT_W'(1));
  assign fire     = in_vld && ob_free;
  assign s_tready = !in_vld || ob_free;

  assign m_tvalid = ob_vld;
  assign m_tdata  = ob_byte;
  assign m_tuser  = ob_kind;
  assign m_tlast  = (ob_cnt == CNT_W'(1));

  csd_step #(
    .MAX_RUN_LENGTH(MAX_RUN_LENGTH),
    .MIN_DEPTH     (MIN_DEPTH),
    .CNT_W         (CNT_W)
  ) u_step (
    .cfg      (cfg),
    .st       (st),
    .in_byte  (in_byte),
    .st_next  (st_next),
    .emit_vld (emit_vld),
    .emit_kind(emit_kind),
    .emit_byte(emit_byte),
    .emit_cnt (emit_cnt)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim    <= csd_pkg::DELIM_RST;
      cfg.depth    <= csd_pkg::DEPTH_RST;
      cfg.run_len  <= csd_pkg::RUN_LEN_RST;
      cfg.run_byte <= csd_pkg::RUN_BYTE_RST;
    end else if (cfg_we) begin
      case (csd_pkg::csd_reg_t'(cfg_index))
        csd_pkg::REG_DELIM:    cfg.delim    <= cfg_data;
        csd_pkg::REG_DEPTH:    cfg.depth    <= cfg_data;
        csd_pkg::REG_RUN_LEN:  cfg.run_len  <= cfg_data[3:0];
        csd_pkg::REG_RUN_BYTE: cfg.run_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control: valid flags, burst count and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld      <= 1'b0;
      ob_vld      <= 1'b0;
      ob_cnt      <= CNT_W'(1);
      st.mode     <= csd_pkg::MODE_CODE;
      st.swap_cnt <= 8'd0;
      st.blk_cnt  <= csd_pkg::BLK_CNT_RST;
      st.run_pend <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_vld <= 1'b1;
      end else if (fire) begin
        in_vld <= 1'b0;
      end
      if (fire) begin
        st     <= st_next;
        ob_vld <= emit_vld;
        ob_cnt <= emit_cnt;
      end else if (ob_vld && m_tready) begin
        // last result of the burst leaves with nothing to replace it
        if (ob_cnt == CNT_W'(1)) begin
          ob_vld <= 1'b0;
        end else begin
          ob_cnt <= ob_cnt - CNT_W'(1);
        end
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (fire) begin
      ob_kind <= emit_kind;
      ob_byte <= emit_byte;
    end
  end

  // A pending burst always has results left, and never more than a full run.
  a_burst_count: assert property (@(posedge clk) disable iff (rst)
    ob_vld |-> (ob_cnt != '0 && ob_cnt <= CNT_W'(MAX_RUN_LENGTH)))
    else $error("result burst count out of range");

  // Frame end and error are single results with a zero byte.
  a_ctrl_single: assert property (@(posedge clk) disable iff (rst)
    (ob_vld && ob_kind != csd_pkg::KIND_DATA) |-> (ob_cnt == CNT_W'(1) && ob_byte == 8'd0))
    else $error("control result not single or byte not zero");

  // The block counter reloads before it can sit at zero.
  a_blk_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.blk_cnt != 8'd0)
    else $error("block countdown at zero");

  // Multi-result bursts only come from an implied run.
  a_run_origin: assert property (@(posedge clk) disable iff (rst)
    (fire && emit_vld && emit_cnt != CNT_W'(1)) |-> st.mode == csd_pkg::MODE_RUN)
    else $error("burst outside implied run");

endmodule

/* sim/cobs_stream_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module cobs_stream_decoder_unit_tb;

  localparam int MAX_RUN      = 8;
  localparam int DEPTH_FLOOR  = 2;
  localparam int SETTLE       = 6;     // a byte with no result may still be in flight
  localparam int TAIL         = 12;    // quiet cycles before the verdict
  localparam int STALL_LIMIT  = 3000;  // cycles with no transfer on either side

  // One decoded result as seen on the master side.
  typedef struct packed {
    csd_pkg::csd_kind_t kind;
    logic [7:0]         data;
    logic               last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = csd_pkg::REG_DELIM;
  logic [7:0] cfg_data = 8'h00;

  cobs_stream_decoder_unit #(
    .MAX_RUN_LENGTH(MAX_RUN),
    .MIN_DEPTH     (DEPTH_FLOOR)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Encoded bytes waiting to be sent, decoded results waiting to arrive.
  logic [7:0] byte_q[$];
  decoded_t   decoded_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count = 0;
  int stall_cycles = 0;
  decoded_t want_res;

  // Shadow registers and decoder state.
  logic [7:0]         dlm_reg;
  logic [7:0]         depth_reg;
  logic [3:0]         run_len_reg;
  logic [7:0]         run_byte_reg;
  csd_pkg::csd_mode_t dec_mode;
  logic [7:0]         swap_left;
  logic [7:0]         blk_left;
  logic               run_due;

  // Run length in force: below 2 is off, above the max saturates.
  function automatic logic [3:0] run_len_eff();
    if (run_len_reg < 4'd2) return 4'd0;
    if (run_len_reg > 4'(MAX_RUN)) return 4'(MAX_RUN);
    return run_len_reg;
  endfunction

  // Depth in force: 127 cap with runs on, then the floor.
  function automatic logic [7:0] depth_eff();
    logic [7:0] d;
    d = depth_reg;
    if (run_len_eff() != 4'd0 && d > csd_pkg::SWAP_LIMIT) d = csd_pkg::SWAP_LIMIT;
    if (d < 8'(DEPTH_FLOOR)) d = 8'(DEPTH_FLOOR);
    return d;
  endfunction

  function automatic void push_result(input csd_pkg::csd_kind_t k, input logic [7:0] v);
    decoded_t r;
    r.kind = k;
    r.data = (k == csd_pkg::KIND_DATA) ? v : 8'h00;
    r.last = 1'b0;
    decoded_q.push_back(r);
  endfunction

  // Advance the decoder state by one encoded byte and queue its results.
  function automatic void decode_in_byte(input logic [7:0] b);
    logic [7:0]         depth;
    logic [7:0]         code;
    logic [3:0]         rl;
    csd_pkg::csd_mode_t prev;
    bit                 bad_code;
    int                 first;
    decoded_t           tail;
    depth    = depth_eff();
    rl       = run_len_eff();
    first    = decoded_q.size();
    bad_code = 1'b0;
    if (b == dlm_reg) begin
      // delimiter: frame end, or error if the block was still open
      push_result((dec_mode != csd_pkg::MODE_DATA) ? csd_pkg::KIND_END : csd_pkg::KIND_ERR,
                  8'h00);
      dec_mode = csd_pkg::MODE_CODE;
      blk_left = depth;
    end else begin
      if (dec_mode == csd_pkg::MODE_DATA) begin
        push_result(csd_pkg::KIND_DATA, b);
      end else begin
        prev = dec_mode;
        // encoder swapped code == delimiter for a zero byte
        code = (dlm_reg != 8'h00 && b == 8'h00) ? dlm_reg : b;
        run_due = (rl != 4'd0 && code > csd_pkg::SWAP_LIMIT);
        if (run_due) code = code - csd_pkg::SWAP_LIMIT;
        swap_left = code;
        blk_left  = depth;
        if (code == 8'h00 || code > depth) begin
          // bad code: pending run or delimiter dropped
          bad_code = 1'b1;
          dec_mode = csd_pkg::MODE_CODE;
          push_result(csd_pkg::KIND_ERR, 8'h00);
        end else if (prev == csd_pkg::MODE_RUN) begin
          repeat (rl) push_result(csd_pkg::KIND_DATA, run_byte_reg);
        end else if (prev == csd_pkg::MODE_DELIM) begin
          push_result(csd_pkg::KIND_DATA, dlm_reg);
        end
      end
      if (!bad_code) begin
        swap_left = swap_left - 8'd1;
        blk_left  = blk_left - 8'd1;
        if (blk_left == 8'h00) begin
          // block full: implied delimiter at this spot is dropped
          dec_mode = csd_pkg::MODE_CODE;
          blk_left = depth;
        end else if (swap_left == 8'h00) begin
          dec_mode = run_due ? csd_pkg::MODE_RUN : csd_pkg::MODE_DELIM;
        end else begin
          dec_mode = csd_pkg::MODE_DATA;
        end
      end
    end
    if (decoded_q.size() > first) begin
      tail = decoded_q.pop_back();
      tail.last = 1'b1;
      decoded_q.push_back(tail);
    end
  endfunction

  // Sender: holds a request until taken, predicts on each accepted byte.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_in_byte(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, checks each result against the oldest one due.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result kind=%0d byte=%02h last=%0b",
                   $time, m_tuser, m_tdata, m_tlast);
        end else begin
          want_res = decoded_q.pop_front();
          if (m_tuser !== want_res.kind || m_tdata !== want_res.data ||
              m_tlast !== want_res.last) begin
            fail_count++;
            $display("%0t: mismatch exp kind=%0d byte=%02h last=%0b got kind=%0d byte=%02h last=%0b",
                     $time, want_res.kind, want_res.data, want_res.last,
                     m_tuser, m_tdata, m_tlast);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: no transfer on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sender stays quiet until every byte is taken and every result is back.
  task automatic wait_drained();
    @(negedge clk);
    while (byte_q.size() != 0 || s_tvalid || decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write all four registers back to back; decoder is idle here.
  task automatic load_regs(input logic [7:0] dlm, input logic [7:0] depth,
                           input logic [3:0] run_len, input logic [7:0] run_byte);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= csd_pkg::REG_DELIM;
    cfg_data  <= dlm;
    @(posedge clk);
    cfg_index <= csd_pkg::REG_DEPTH;
    cfg_data  <= depth;
    @(posedge clk);
    cfg_index <= csd_pkg::REG_RUN_LEN;
    cfg_data  <= {4'h0, run_len};
    @(posedge clk);
    cfg_index <= csd_pkg::REG_RUN_BYTE;
    cfg_data  <= run_byte;
    @(posedge clk);
    cfg_we <= 1'b0;
    dlm_reg      = dlm;
    depth_reg    = depth;
    run_len_reg  = run_len;
    run_byte_reg = run_byte;
    @(negedge clk);
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] d;
    d = 8'($urandom_range(255));
    while (d == dlm_reg) d = 8'($urandom_range(255));
    return d;
  endfunction

  // Well-formed frame: 1..4 blocks of short codes, now and then a full block
  // or a run code, closed by the delimiter.
  function automatic int push_frame();
    logic [7:0] depth;
    logic [7:0] code_val;
    int         c;
    int         cnt;
    bit         with_run;
    depth = depth_eff();
    cnt   = 0;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(19) == 0) c = depth;
      else c = $urandom_range(1, (depth < 6) ? depth : 6);
      with_run = (run_len_eff() != 4'd0) && ($urandom_range(1) == 1);
      code_val = with_run ? 8'(c + 127) : 8'(c);
      byte_q.push_back((dlm_reg != 8'h00 && code_val == dlm_reg) ? 8'h00 : code_val);
      cnt++;
      repeat (c - 1) begin
        byte_q.push_back(data_byte());
        cnt++;
      end
    end
    byte_q.push_back(dlm_reg);
    return cnt + 1;
  endfunction

  // Raw junk, sometimes closed by a delimiter mid-block.
  function automatic int push_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) byte_q.push_back(8'($urandom_range(255)));
    if ($urandom_range(2) == 0) begin
      byte_q.push_back(dlm_reg);
      n++;
    end
    return n;
  endfunction

  // Mostly frames, some noise; halfway through the sender waits for a full drain.
  task automatic fill_random(input int target);
    int  pushed;
    bit  paused;
    pushed = 0;
    paused = 1'b0;
    while (pushed < target) begin
      if (!paused && pushed >= target / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 80) pushed += push_frame();
      else pushed += push_noise();
    end
  endtask

  initial begin
    dlm_reg      = csd_pkg::DELIM_RST;
    depth_reg    = csd_pkg::DEPTH_RST;
    run_len_reg  = csd_pkg::RUN_LEN_RST;
    run_byte_reg = csd_pkg::RUN_BYTE_RST;
    dec_mode     = csd_pkg::MODE_CODE;
    swap_left    = 8'h00;
    blk_left     = csd_pkg::BLK_CNT_RST;
    run_due      = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 86;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset registers: end on empty frame, code 1 then code 2 (implied
    // delimiter), data 0xFF, delimiter with implied delimiter pending,
    // delimiter mid-block twice, largest code.
    byte_q = '{8'h00, 8'h01, 8'h02, 8'hFF, 8'h00, 8'h03, 8'h00, 8'hFF, 8'h00};
    wait_drained();

    // Depth below floor, run length 1 (off): swapped code too big, full block
    // dropping its delimiter, frame end, oversize code.
    load_regs(8'h5A, 8'h01, 4'd1, 8'hA5);
    byte_q = '{8'h00, 8'h02, 8'h11, 8'h01, 8'h5A, 8'h03};
    wait_drained();

    // Runs on, depth capped at 127: run emitted on next code, largest run
    // code, delimiter mid-block, run after run, swapped code past the cap.
    load_regs(8'hFF, 8'd200, 4'd3, 8'h77);
    byte_q = '{8'h81, 8'h00, 8'h01, 8'hFF, 8'hFE, 8'hFF, 8'h80, 8'h80, 8'hFF,
               8'h00};
    wait_drained();

    load_regs(8'h00, 8'd255, 4'd0, 8'h00);
    fill_random(40);
    wait_drained();
    load_regs(8'hFF, 8'd127, 4'd8, 8'hFF);
    fill_random(40);
    wait_drained();

    send_idle_pct = 86;
    recv_idle_pct = 35;
    load_regs(8'($urandom_range(255)), 8'd2, 4'd2, 8'($urandom_range(255)));
    fill_random(40);
    wait_drained();
    load_regs(8'h80, 8'd255, 4'd15, 8'h55);
    fill_random(40);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_regs(8'($urandom_range(255)), 8'($urandom_range(1, 255)),
              4'($urandom_range(8)), 8'($urandom_range(255)));
    fill_random(40);
    wait_drained();
    load_regs(8'h01, 8'd1, 4'd0, 8'hAA);
    fill_random(40);

    wait_drained();
    repeat (TAIL) @(negedge clk);
    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* cobs_stream_decoder_unit.f */
design/csd_pkg.sv
design/csd_step.sv
design/cobs_stream_decoder_unit.sv
sim/cobs_stream_decoder_unit_tb.sv
